/* rtl/core/magnetometer_heading_angles_top_defines.svh */
// Assertion macros for the magnetometer heading block checker.
// Used by magnetometer_heading_angles_chk.sv only.
`ifndef MAGNETOMETER_HEADING_ANGLES_TOP_DEFINES_SVH
`define MAGNETOMETER_HEADING_ANGLES_TOP_DEFINES_SVH
// Assert that a condition implies a property on the same edge.
`define MHA_ASSERT_IMPL(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Assert that a condition implies a property on the next edge.
`define MHA_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

/* rtl/core/mha_pkg.sv */
// Shared constants and types for the magnetometer heading block.
// No dependencies.
`timescale 1ns / 1ps
package mha_pkg;
    localparam int unsigned Steps   = 24;
    localparam int unsigned AngFrac = 20;
    // Datapath widths: operands up to 2^15 scaled by 2^24 grow by ~1.65.
    localparam int unsigned DW = 42;
    localparam int unsigned ZW = 30;

    typedef logic signed [DW-1:0] dp_t;
    typedef logic signed [ZW-1:0] ang_t;

    // Special-case handling of a first-quadrant vector.
    typedef enum logic [1:0] {
        FQ_CORDIC = 2'd0,
        FQ_ZERO   = 2'd1,
        FQ_HALF   = 2'd2
    } fq_mode_t;

    // Per-angle lane state carried through the CORDIC stages.
    typedef struct packed {
        dp_t      px;
        dp_t      py;
        ang_t     z;
        logic [1:0] quad;
        fq_mode_t mode;
    } lane_t;

    // atan(2^-i) in degrees, scaled by 2^20.
    function automatic ang_t atan_tab(input logic [4:0] i);
        ang_t r;
        case (i)
            5'd0:  r = ang_t'(47185920);
            5'd1:  r = ang_t'(27855475);
            5'd2:  r = ang_t'(14718068);
            5'd3:  r = ang_t'(7471121);
            5'd4:  r = ang_t'(3750058);
            5'd5:  r = ang_t'(1876857);
            5'd6:  r = ang_t'(938658);
            5'd7:  r = ang_t'(469357);
            5'd8:  r = ang_t'(234682);
            5'd9:  r = ang_t'(117342);
            5'd10: r = ang_t'(58671);
            5'd11: r = ang_t'(29335);
            5'd12: r = ang_t'(14668);
            5'd13: r = ang_t'(7334);
            5'd14: r = ang_t'(3667);
            5'd15: r = ang_t'(1833);
            5'd16: r = ang_t'(917);
            5'd17: r = ang_t'(458);
            5'd18: r = ang_t'(229);
            5'd19: r = ang_t'(115);
            5'd20: r = ang_t'(57);
            5'd21: r = ang_t'(29);
            5'd22: r = ang_t'(14);
            5'd23: r = ang_t'(7);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

/* rtl/core/magnetometer_heading_angles_top.sv */
// Top level of the magnetometer heading block.
// Depends on mha_pkg, mha_reduce and mha_cordic_step.
`timescale 1ns / 1ps
// Takes one reading per clock whenever start is high (busy is tied low),
// and strobes done with the three raw values and three angles once the
// reading has passed one register after packing and quadrant reduction,
// 24 CORDIC iteration stages, and one output register for angle assembly.
// The receiver cannot stall; results appear in input order.
module magnetometer_heading_angles_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         x_high_byte,
    input  logic [7:0]         x_low_byte,
    input  logic [7:0]         y_high_byte,
    input  logic [7:0]         y_low_byte,
    input  logic [7:0]         z_high_byte,
    input  logic [7:0]         z_low_byte,
    output logic               done,
    output logic signed [15:0] raw_x,
    output logic signed [15:0] raw_y,
    output logic signed [15:0] raw_z,
    output logic [8:0]         bearing_deg,
    output logic [8:0]         roll_deg,
    output logic [8:0]         pitch_deg
);
    localparam int unsigned N = mha_pkg::Steps;

    logic signed [16:0]   x, y, z;
    mha_pkg::lane_t [2:0] red_lane;
    logic                 v_reg [N+1];
    mha_pkg::lane_t [2:0] l_reg [N+1];
    logic [47:0]          r_reg [N+1];
    logic [8:0]           ang_next [3];
    logic                 done_reg;
    logic [47:0]          raw_reg;
    logic [8:0]           ang_reg [3];

    assign busy = 1'b0;

    // Pack bytes and form the three atan2 operand pairs
    assign x = 17'(signed'({x_high_byte, x_low_byte}));
    assign y = 17'(signed'({y_high_byte, y_low_byte}));
    assign z = 17'(signed'({z_high_byte, z_low_byte}));

    mha_reduce u_red_b (.s(x), .c(-y), .lane(red_lane[0]));
    mha_reduce u_red_r (.s(x), .c(-z), .lane(red_lane[1]));
    mha_reduce u_red_p (.s(y), .c(-z), .lane(red_lane[2]));

    // Register the reduced lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= start;
    end

    always_ff @(posedge clk)
    begin
        l_reg[0] <= red_lane;
        r_reg[0] <= {x_high_byte, x_low_byte, y_high_byte, y_low_byte,
                     z_high_byte, z_low_byte};
    end

    // CORDIC iteration stages
    for (genvar g = 0; g < N; g++)
    begin : g_step
        mha_cordic_step #(.Idx(g)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v_reg[g]),
            .in_lane  (l_reg[g]),
            .in_raw   (r_reg[g]),
            .out_valid(v_reg[g+1]),
            .out_lane (l_reg[g+1]),
            .out_raw  (r_reg[g+1])
        );
    end

    // Clamp the residual angle, apply the exact cases and add the quadrant offset
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [6:0] a;
            mha_pkg::ang_t zz;
            zz = l_reg[N][k].z;
            if (zz < 0)
                a = 7'd0;
            else if ((zz >>> mha_pkg::AngFrac) > 89)
                a = 7'd89;
            else
                a = 7'(zz >>> mha_pkg::AngFrac);
            case (l_reg[N][k].mode)
                mha_pkg::FQ_ZERO: a = 7'd0;
                mha_pkg::FQ_HALF: a = 7'd45;
                default: ;
            endcase
            ang_next[k] = 9'(l_reg[N][k].quad) * 9'd90 + 9'(a);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_reg[N];
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= r_reg[N];
        for (int k = 0; k < 3; k++)
            ang_reg[k] <= ang_next[k];
    end

    assign done        = done_reg;
    assign raw_x       = signed'(raw_reg[47:32]);
    assign raw_y       = signed'(raw_reg[31:16]);
    assign raw_z       = signed'(raw_reg[15:0]);
    assign bearing_deg = ang_reg[0];
    assign roll_deg    = ang_reg[1];
    assign pitch_deg   = ang_reg[2];
endmodule

/* rtl/core/mha_reduce.sv */
// Quadrant reduction of atan2(s, c) into a first-quadrant CORDIC lane.
// Depends on mha_pkg.
`timescale 1ns / 1ps
module mha_reduce (
    input  logic signed [16:0] s,
    input  logic signed [16:0] c,
    output mha_pkg::lane_t     lane
);
    logic signed [16:0] u;
    logic signed [16:0] v;
    logic [1:0]         q;

    // Pick the quadrant and rotate by a multiple of 90 degrees
    always_comb
    begin
        if (s >= 0 && c > 0)
        begin
            q = 2'd0; u = c;  v = s;
        end
        else if (c <= 0 && s > 0)
        begin
            q = 2'd1; u = s;  v = -c;
        end
        else if (s <= 0 && c < 0)
        begin
            q = 2'd2; u = -c; v = -s;
        end
        else
        begin
            q = 2'd3; u = -s; v = c;
        end
    end

    // Scale by 2^24 and flag the exact cases
    always_comb
    begin
        lane.px   = mha_pkg::dp_t'(u) <<< 24;
        lane.py   = mha_pkg::dp_t'(v) <<< 24;
        lane.z    = '0;
        lane.quad = q;
        if (s == 0 && c == 0)
        begin
            lane.quad = 2'd0;
            lane.mode = mha_pkg::FQ_ZERO;
        end
        else if (v == 0)
            lane.mode = mha_pkg::FQ_ZERO;
        else if (u == v)
            lane.mode = mha_pkg::FQ_HALF;
        else
            lane.mode = mha_pkg::FQ_CORDIC;
    end
endmodule

/* rtl/core/mha_cordic_step.sv */
// One vectoring CORDIC iteration on three lanes, registered.
// Depends on mha_pkg.
`timescale 1ns / 1ps
module mha_cordic_step #(
    parameter int unsigned Idx = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  mha_pkg::lane_t [2:0] in_lane,
    input  logic [47:0]          in_raw,
    output logic                 out_valid,
    output mha_pkg::lane_t [2:0] out_lane,
    output logic [47:0]          out_raw
);
    mha_pkg::lane_t [2:0] lane_next;
    logic                 valid_reg;
    mha_pkg::lane_t [2:0] lane_reg;
    logic [47:0]          raw_reg;

    // Rotate each lane toward the positive x axis
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_next[k] = in_lane[k];
            if (in_lane[k].py >= 0)
            begin
                lane_next[k].px = in_lane[k].px + (in_lane[k].py >>> Idx);
                lane_next[k].py = in_lane[k].py - (in_lane[k].px >>> Idx);
                lane_next[k].z  = in_lane[k].z + mha_pkg::atan_tab(5'(Idx));
            end
            else
            begin
                lane_next[k].px = in_lane[k].px - (in_lane[k].py >>> Idx);
                lane_next[k].py = in_lane[k].py + (in_lane[k].px >>> Idx);
                lane_next[k].z  = in_lane[k].z - mha_pkg::atan_tab(5'(Idx));
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        raw_reg  <= in_raw;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
    assign out_raw   = raw_reg;
endmodule

/* rtl/core/magnetometer_heading_angles_chk.sv */
// Port-level checker for the magnetometer heading block, with its bind.
// Depends on magnetometer_heading_angles_top_defines.svh.
`timescale 1ns / 1ps
`include "magnetometer_heading_angles_top_defines.svh"
module magnetometer_heading_angles_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [8:0] bearing_deg,
    input logic [8:0] roll_deg,
    input logic [8:0] pitch_deg
);
    // Check angles stay below a full turn
    `MHA_ASSERT_IMPL(a_bear_rng, done, bearing_deg < 9'd360, "bearing out of range")
    `MHA_ASSERT_IMPL(a_roll_rng, done, roll_deg < 9'd360, "roll out of range")
    `MHA_ASSERT_IMPL(a_pitch_rng, done, pitch_deg < 9'd360, "pitch out of range")
    // Check that each accepted item is followed by a result
    `MHA_ASSERT_IMPL(a_lat, $past(start && !busy, 26), done, "result missing")
    `MHA_ASSERT_NEXT(a_nobusy, 1'b1, !busy, "block stalled")
endmodule

bind magnetometer_heading_angles_top magnetometer_heading_angles_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .bearing_deg(bearing_deg), .roll_deg(roll_deg), .pitch_deg(pitch_deg)
);

/* tb/testbench.sv */
// Testbench for magnetometer_heading_angles_top: packed readings and heading angles.
// Depends on the RTL top level only; a built-in fixed-point atan2 predicts each result.
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic [7:0] xh, xl, yh, yl, zh, zl;
        int unsigned gap;
    } reading_t;

    typedef struct {
        logic signed [15:0] rx, ry, rz;
        logic [8:0] brg, rol, pit;
    } heading_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [7:0] x_high_byte, x_low_byte, y_high_byte, y_low_byte, z_high_byte, z_low_byte;
    logic done;
    logic signed [15:0] raw_x, raw_y, raw_z;
    logic [8:0] bearing_deg, roll_deg, pitch_deg;

    reading_t pending_q[$];
    heading_t heading_q[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned wait_count;
    bit stim_done;

    localparam int unsigned CycleLimit = 400000;

    magnetometer_heading_angles_top i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_high_byte(x_high_byte), .x_low_byte(x_low_byte),
        .y_high_byte(y_high_byte), .y_low_byte(y_low_byte),
        .z_high_byte(z_high_byte), .z_low_byte(z_low_byte),
        .done(done), .raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
        .bearing_deg(bearing_deg), .roll_deg(roll_deg), .pitch_deg(pitch_deg)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // atan(2^-i) in degrees scaled by 2^20
    function automatic longint atan_step(input int i);
        longint t[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                          938658, 469357, 234682, 117342, 58671, 29335,
                          14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return t[i];
    endfunction

    // Angle of (u, v) with u > 0, v >= 0, in whole degrees 0..89
    function automatic int unsigned quadrant_angle(input longint u, input longint v);
        longint px, py, nx, acc;
        acc = 0;
        if (v == 0)
            return 0;
        if (u == v)
            return 45;
        px = u <<< 24;
        py = v <<< 24;
        for (int i = 0; i < 24; i++)
        begin
            if (py >= 0)
            begin
                nx = px + (py >>> i);
                py = py - (px >>> i);
                acc += atan_step(i);
            end
            else
            begin
                nx = px - (py >>> i);
                py = py + (px >>> i);
                acc -= atan_step(i);
            end
            px = nx;
        end
        if (acc < 0)
            return 0;
        acc = acc >>> 20;
        return (acc > 89) ? 89 : int'(acc);
    endfunction

    // atan2(s, c) in degrees 0..359 by exact quarter-turn reduction
    function automatic logic [8:0] compass_angle(input longint s, input longint c);
        if (s == 0 && c == 0)
            return 0;
        if (s >= 0 && c > 0)
            return 9'(quadrant_angle(c, s));
        if (c <= 0 && s > 0)
            return 9'(90 + quadrant_angle(s, -c));
        if (s <= 0 && c < 0)
            return 9'(180 + quadrant_angle(-c, -s));
        return 9'(270 + quadrant_angle(-s, c));
    endfunction

    function automatic heading_t predict_heading(input reading_t r);
        heading_t h;
        longint x, y, z;
        h.rx = {r.xh, r.xl};
        h.ry = {r.yh, r.yl};
        h.rz = {r.zh, r.zl};
        x = h.rx;
        y = h.ry;
        z = h.rz;
        h.brg = compass_angle(x, -y);
        h.rol = compass_angle(x, -z);
        h.pit = compass_angle(y, -z);
        return h;
    endfunction

    task automatic add_reading(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input bit idle_ok);
        reading_t r;
        r.xh = x[15:8];
        r.xl = x[7:0];
        r.yh = y[15:8];
        r.yl = y[7:0];
        r.zh = z[15:8];
        r.zl = z[7:0];
        r.gap = idle_ok ? $urandom_range(0, 15) : 0;
        pending_q.push_back(r);
    endtask

    function automatic logic [15:0] random_axis();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // Fill the item queue: directed corners, then random readings
    initial
    begin
        logic [15:0] a;
        add_reading(16'h0000, 16'h0000, 16'h0000, 0);
        add_reading(16'h8000, 16'h8000, 16'h8000, 0);
        add_reading(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        add_reading(16'hFFFF, 16'h0001, 16'hFFFF, 0);
        add_reading(16'h0100, 16'h0000, 16'h0000, 0);
        add_reading(16'h0000, 16'h0100, 16'h0000, 0);
        add_reading(16'h0000, 16'hFF00, 16'h0000, 0);
        add_reading(16'hFF00, 16'h0000, 16'h0000, 0);
        add_reading(16'h0000, 16'h0000, 16'h0100, 0);
        add_reading(16'h0000, 16'h0000, 16'hFF00, 0);
        add_reading(16'h0064, 16'hFF9C, 16'hFF9C, 0);
        add_reading(16'h0064, 16'h0064, 16'h0064, 0);
        add_reading(16'hFF9C, 16'h0064, 16'hFF9C, 0);
        add_reading(16'h8000, 16'h7FFF, 16'h8000, 0);
        add_reading(16'h7FFF, 16'h8000, 16'h0001, 0);
        add_reading(16'hAA55, 16'h55AA, 16'hA5A5, 0);
        add_reading(16'h55AA, 16'hAA55, 16'h5A5A, 0);
        add_reading(16'h0001, 16'h7FFF, 16'h8000, 0);
        for (int n = 0; n < 1200; n++)
        begin
            a = random_axis();
            if ($urandom_range(0, 7) == 0)
                add_reading(a, 16'(-$signed(a)), random_axis(), $urandom_range(0, 3) != 0);
            else
                add_reading(random_axis(), random_axis(), random_axis(),
                            $urandom_range(0, 3) != 0);
        end
    end

    // Reset, then watch for the drain and the cycle limit
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && heading_q.size() == 0);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        error_count = 0;
        wait_count = 0;
        stim_done = 1'b0;
        start = 1'b0;
        {x_high_byte, x_low_byte, y_high_byte, y_low_byte, z_high_byte, z_low_byte} = '0;
    end

    // Drive items at the falling edge; hold the current one until accepted
    always @(negedge clk)
    begin
        reading_t r;
        if (rst_n)
        begin
            if (start && busy)
            begin
                // hold: not yet accepted
            end
            else if (wait_count != 0)
            begin
                start <= 1'b0;
                wait_count <= wait_count - 1;
            end
            else if (pending_q.size() != 0)
            begin
                r = pending_q.pop_front();
                if (r.gap != 0 && start)
                begin
                    pending_q.push_front(r);
                    pending_q[0].gap = 0;
                    start <= 1'b0;
                    wait_count <= r.gap - 1;
                end
                else
                begin
                    start <= 1'b1;
                    x_high_byte <= r.xh;
                    x_low_byte <= r.xl;
                    y_high_byte <= r.yh;
                    y_low_byte <= r.yl;
                    z_high_byte <= r.zh;
                    z_low_byte <= r.zl;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Record expectations for accepted items and check each strobed result
    always @(posedge clk)
    begin
        reading_t r;
        heading_t e;
        if (rst_n && start && !busy)
        begin
            r.xh = x_high_byte;
            r.xl = x_low_byte;
            r.yh = y_high_byte;
            r.yl = y_low_byte;
            r.zh = z_high_byte;
            r.zl = z_low_byte;
            heading_q.push_back(predict_heading(r));
            if (pending_q.size() == 0)
                stim_done = 1'b1;
        end
        if (rst_n && done)
        begin
            if (heading_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: x %0d y %0d z %0d", $time,
                         raw_x, raw_y, raw_z);
                error_count++;
            end
            else
            begin
                e = heading_q.pop_front();
                if (raw_x !== e.rx)
                begin
                    $display("%0t: raw_x expected %0d got %0d", $time, e.rx, raw_x);
                    error_count++;
                end
                if (raw_y !== e.ry)
                begin
                    $display("%0t: raw_y expected %0d got %0d", $time, e.ry, raw_y);
                    error_count++;
                end
                if (raw_z !== e.rz)
                begin
                    $display("%0t: raw_z expected %0d got %0d", $time, e.rz, raw_z);
                    error_count++;
                end
                if (bearing_deg !== e.brg)
                begin
                    $display("%0t: bearing_deg expected %0d got %0d", $time, e.brg,
                             bearing_deg);
                    error_count++;
                end
                if (roll_deg !== e.rol)
                begin
                    $display("%0t: roll_deg expected %0d got %0d", $time, e.rol, roll_deg);
                    error_count++;
                end
                if (pitch_deg !== e.pit)
                begin
                    $display("%0t: pitch_deg expected %0d got %0d", $time, e.pit,
                             pitch_deg);
                    error_count++;
                end
            end
        end
    end
endmodule
